// ===== sv/bcage_pkg.sv =====
// Shared constants, types and the cell update rule of the cellular automaton engine.
package bcage_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int SIZE_W   = 7;
  localparam int GEN_W    = 16;
  localparam int CNT_W    = 13;
  localparam int CFG_IW   = 2;
  localparam int NSUM_W   = 4;

  localparam logic [SIZE_W-1:0] ROWS_RESET = SIZE_W'(64);
  localparam logic [SIZE_W-1:0] COLS_RESET = SIZE_W'(64);
  localparam logic [CNT_W-1:0]  CNT_MAX    = '1;

  localparam logic [NSUM_W-1:0] LIFE_BIRTH   = NSUM_W'(3);
  localparam logic [NSUM_W-1:0] LIFE_SURVIVE = NSUM_W'(2);

  // Bit i is the anneal vote result for a nine-cell sum of i.
  localparam logic [9:0] VOTE_TABLE = 10'b11_1101_0000;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ROWS = 2'd0,
    CFG_COLS = 2'd1,
    CFG_RULE = 2'd2,
    CFG_WRAP = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RMW_RD,
    S_RMW_DATA,
    S_GEN_TOP,
    S_GEN_ROW0,
    S_GEN_FIRST,
    S_GEN_BELOW,
    S_GEN_BWAIT,
    S_GEN_CELL,
    S_GEN_WB,
    S_CNT_RD,
    S_CNT_WAIT,
    S_CNT_CELL,
    S_DONE
  } state_t;

  // Next value of one cell from its eight-neighbour sum and its own value.
  function automatic logic next_cell(logic [NSUM_W-1:0] nsum, logic self, logic vote);
    logic [NSUM_W-1:0] idx;
    idx = nsum + NSUM_W'(self);
    if (vote) begin
      return VOTE_TABLE[idx];
    end
    return (nsum == LIFE_BIRTH) || ((nsum == LIFE_SURVIVE) && self);
  endfunction

endpackage

// ===== sv/bcage_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module bcage_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/binary_ca_generation_engine_top.sv =====
// Top level of the binary cellular automaton generation engine.
//
// The engine keeps a grid of one-bit cells, MAX_ROWS by MAX_COLS, of which the
// top-left grid_rows by grid_cols cells are in use (a size of zero acts as one,
// a size above the maximum saturates). Each input transaction writes one cell,
// reads one cell, or advances the used grid by generation_count generations;
// each produces exactly one output transaction carrying the read cell (zero
// for anything but an in-range read) and the live count of the used grid. In
// a generation every used cell is updated at once from its Moore
// neighbourhood: Life rule (birth on 3, survive on 2 or 3) or the nine-cell
// anneal vote, with edges that wrap as a torus or count as dead. The grid is
// held one row per RAM word; a row-valid bit per row makes a never-written
// row read as dead, so there is no clearing pass after reset. Work is done by
// one cell evaluator and one counter that step through the grid one cell per
// cycle, with the rows above, at and below the current row held in registers.
// The single RAM port pair sets the pace. A write or read inside the used grid
// passes, between one accepted transaction and the next, through the accepting
// idle state, a read-modify-write, the live count pass over the used grid and
// the loading of the result. Other transactions skip the read-modify-write,
// and an advance runs its generations before the live count pass. in_ready
// is low while a transaction is being worked on; a finished result sits in the
// output register, so the next input transaction can be taken while it waits.
// Configuration is to be written only while the engine is idle; the block does
// not enforce this itself, and cfg_ready is tied high.
module binary_ca_generation_engine_top
  import bcage_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        operation,
  input  logic [5:0]        row_index,
  input  logic [5:0]        col_index,
  input  logic              cell_in,
  input  logic [GEN_W-1:0]  generation_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              cell_out,
  output logic [CNT_W-1:0]  live_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  // Configuration registers.
  logic [SIZE_W-1:0] grid_rows;
  logic [SIZE_W-1:0] grid_cols;
  logic              rule_select;
  logic              wrap_edges;

  // Sequencer and datapath registers.
  state_t              state, state_next;
  logic [1:0]          op_q;
  logic [ROW_W-1:0]    row_q;
  logic [COL_W-1:0]    col_q;
  logic                val_q;
  logic [GEN_W-1:0]    gens_left;
  logic [ROW_W-1:0]    row_cnt;
  logic [COL_W-1:0]    col;
  logic [MAX_COLS-1:0] above;
  logic [MAX_COLS-1:0] cur;
  logic [MAX_COLS-1:0] below;
  logic [MAX_COLS-1:0] top_old;
  logic [MAX_COLS-1:0] new_row;
  logic [CNT_W-1:0]    acc;
  logic                cell_res;
  logic [MAX_ROWS-1:0] row_vld;
  logic                rd_vld;

  // RAM port signals.
  logic                ram_we;
  logic [ROW_W-1:0]    ram_waddr;
  logic [MAX_COLS-1:0] ram_wdata;
  logic [ROW_W-1:0]    ram_raddr;
  logic [MAX_COLS-1:0] ram_q;
  logic [MAX_COLS-1:0] rdata;

  // Effective sizes and cell evaluator signals.
  logic [SIZE_W-1:0] rows_used;
  logic [SIZE_W-1:0] cols_used;
  logic [ROW_W-1:0]  last_row;
  logic [COL_W-1:0]  last_col;
  logic              in_grid;
  logic [COL_W-1:0]  left_c;
  logic [COL_W-1:0]  right_c;
  logic              has_l;
  logic              has_r;
  logic [NSUM_W-1:0] nsum;
  logic              cell_next;
  logic              out_free;

  assign cfg_ready = 1'b1;

  // A size of zero behaves as one, and sizes beyond the grid saturate.
  always_comb begin
    if (grid_rows == '0) begin
      rows_used = SIZE_W'(1);
    end else if (grid_rows > SIZE_W'(MAX_ROWS)) begin
      rows_used = SIZE_W'(MAX_ROWS);
    end else begin
      rows_used = grid_rows;
    end
    if (grid_cols == '0) begin
      cols_used = SIZE_W'(1);
    end else if (grid_cols > SIZE_W'(MAX_COLS)) begin
      cols_used = SIZE_W'(MAX_COLS);
    end else begin
      cols_used = grid_cols;
    end
  end

  assign last_row = ROW_W'(rows_used - SIZE_W'(1));
  assign last_col = COL_W'(cols_used - SIZE_W'(1));
  assign in_grid  = (SIZE_W'(row_index) < rows_used) && (SIZE_W'(col_index) < cols_used);

  // Rows never written since reset read as all dead.
  assign rdata = rd_vld ? ram_q : '0;

  // Column neighbours: wrap around the used width, or fall off the edge as dead.
  // With one or two columns the wrapped neighbour can be the cell itself or the
  // same cell on both sides, and it is then counted once per position.
  always_comb begin
    if (col == '0) begin
      left_c = last_col;
      has_l  = wrap_edges;
    end else begin
      left_c = col - COL_W'(1);
      has_l  = 1'b1;
    end
    if (col == last_col) begin
      right_c = '0;
      has_r   = wrap_edges;
    end else begin
      right_c = col + COL_W'(1);
      has_r   = 1'b1;
    end
    nsum = NSUM_W'(above[col]) + NSUM_W'(below[col]);
    if (has_l) begin
      nsum = nsum + NSUM_W'(above[left_c]) + NSUM_W'(cur[left_c]) + NSUM_W'(below[left_c]);
    end
    if (has_r) begin
      nsum = nsum + NSUM_W'(above[right_c]) + NSUM_W'(cur[right_c])
           + NSUM_W'(below[right_c]);
    end
  end

  assign cell_next = next_cell(nsum, cur[col], rule_select);
  assign out_free  = !out_valid || out_ready;

  bcage_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Sequencer: next state, RAM controls and the input handshake.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = row_cnt;
    ram_wdata  = new_row;
    ram_raddr  = row_cnt;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (operation) inside
            OP_WRITE, OP_READ: state_next = in_grid ? S_RMW_RD : S_CNT_RD;
            OP_ADVANCE: state_next = (generation_count == '0) ? S_CNT_RD : S_GEN_TOP;
            default: state_next = S_CNT_RD;
          endcase
        end
      end
      S_RMW_RD: begin
        ram_raddr  = row_q;
        state_next = S_RMW_DATA;
      end
      S_RMW_DATA: begin
        if (op_q == OP_WRITE) begin
          ram_we           = 1'b1;
          ram_waddr        = row_q;
          ram_wdata        = rdata;
          ram_wdata[col_q] = val_q;
        end
        state_next = S_CNT_RD;
      end
      S_GEN_TOP: begin
        ram_raddr  = last_row;
        state_next = S_GEN_ROW0;
      end
      S_GEN_ROW0: begin
        ram_raddr  = '0;
        state_next = S_GEN_FIRST;
      end
      S_GEN_FIRST: begin
        state_next = S_GEN_BELOW;
      end
      S_GEN_BELOW: begin
        ram_raddr  = row_cnt + ROW_W'(1);
        state_next = (row_cnt == last_row) ? S_GEN_CELL : S_GEN_BWAIT;
      end
      S_GEN_BWAIT: begin
        state_next = S_GEN_CELL;
      end
      S_GEN_CELL: begin
        if (col == last_col) begin
          state_next = S_GEN_WB;
        end
      end
      S_GEN_WB: begin
        ram_we = 1'b1;
        if (row_cnt == last_row) begin
          state_next = (gens_left == GEN_W'(1)) ? S_CNT_RD : S_GEN_TOP;
        end else begin
          state_next = S_GEN_BELOW;
        end
      end
      S_CNT_RD: begin
        state_next = S_CNT_WAIT;
      end
      S_CNT_WAIT: begin
        state_next = S_CNT_CELL;
      end
      S_CNT_CELL: begin
        if (col == last_col) begin
          state_next = (row_cnt == last_row) ? S_DONE : S_CNT_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers: configuration, row-valid bits and the output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows   <= ROWS_RESET;
      grid_cols   <= COLS_RESET;
      rule_select <= 1'b0;
      wrap_edges  <= 1'b1;
      row_vld     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ROWS: grid_rows   <= cfg_data;
          CFG_COLS: grid_cols   <= cfg_data;
          CFG_RULE: rule_select <= cfg_data[0];
          CFG_WRAP: wrap_edges  <= cfg_data[0];
          default: ;
        endcase
      end
      if (ram_we) begin
        row_vld[ram_waddr] <= 1'b1;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rd_vld <= row_vld[ram_raddr];

    // Every pass of the live counter starts from the first row with a clear sum.
    if (state_next == S_CNT_RD && state != S_CNT_CELL) begin
      row_cnt <= '0;
      acc     <= '0;
    end

    unique case (state)
      S_IDLE: begin
        op_q      <= operation;
        row_q     <= ROW_W'(row_index);
        col_q     <= COL_W'(col_index);
        val_q     <= cell_in;
        gens_left <= generation_count;
        cell_res  <= 1'b0;
      end
      S_RMW_DATA: begin
        if (op_q == OP_READ) begin
          cell_res <= rdata[col_q];
        end
      end
      S_GEN_ROW0: begin
        above   <= wrap_edges ? rdata : '0;
        row_cnt <= '0;
      end
      S_GEN_FIRST: begin
        cur     <= rdata;
        top_old <= rdata;
      end
      S_GEN_BELOW: begin
        new_row <= cur;
        col     <= '0;
        // The last row's lower neighbour is the old first row, kept aside
        // because the first row has already been overwritten.
        if (row_cnt == last_row) begin
          below <= wrap_edges ? top_old : '0;
        end
      end
      S_GEN_BWAIT: begin
        below <= rdata;
      end
      S_GEN_CELL: begin
        new_row[col] <= cell_next;
        col          <= col + COL_W'(1);
      end
      S_GEN_WB: begin
        above <= cur;
        cur   <= below;
        if (row_cnt == last_row) begin
          gens_left <= gens_left - GEN_W'(1);
        end else begin
          row_cnt <= row_cnt + ROW_W'(1);
        end
      end
      S_CNT_WAIT: begin
        cur <= rdata;
        col <= '0;
      end
      S_CNT_CELL: begin
        if (acc != CNT_MAX) begin
          acc <= acc + CNT_W'(cur[col]);
        end
        col <= col + COL_W'(1);
        if (col == last_col && row_cnt != last_row) begin
          row_cnt <= row_cnt + ROW_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          cell_out   <= cell_res;
          live_count <= acc;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_write_in_used_grid: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (SIZE_W'(ram_waddr) < rows_used))
    else $error("grid write outside the used rows");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_GEN_CELL || state == S_CNT_CELL) |-> (col <= last_col))
    else $error("cell walk beyond the used columns");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again before the transaction was worked on");

  a_result_only_from_done: assert property (@(posedge clk) disable iff (rst)
    (out_ready && state != S_DONE) |=> !out_valid)
    else $error("result shown without a finished transaction");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the binary cellular automaton generation engine.
module tb;
  import bcage_pkg::*;

  // Timing and run-shape constants.
  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 11;
  localparam int IDLE_PERCENT  = 17;
  localparam int SETTLE_CYCLES = 4500;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_ITEMS   = 23;
  localparam int RANDOM_PHASES = 6;
  localparam int STEADY_PHASE  = 2;

  // Grid geometry and update rule, kept independent of the design's own helpers.
  localparam int CELLS       = MAX_ROWS * MAX_COLS;
  localparam int COUNT_CAP   = (1 << CNT_W) - 1;
  localparam int BIRTH_SUM   = 3;
  localparam int SURVIVE_SUM = 2;
  // Bit i tells whether a cell lives when the nine-cell sum is i.
  localparam bit [9:0] ANNEAL_VOTE = 10'b11_1101_0000;
  // The one operation code that the engine must treat as a no-op.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]       op;
    logic [5:0]       row;
    logic [5:0]       col;
    logic             val;
    logic [GEN_W-1:0] gens;
  } ca_item_t;

  typedef struct {
    logic             cell_bit;
    logic [CNT_W-1:0] count;
  } readout_t;

  // Clock, reset and every input of the engine start at known values.
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic [1:0]        operation = '0;
  logic [5:0]        row_index = '0;
  logic [5:0]        col_index = '0;
  logic              cell_in = 1'b0;
  logic [GEN_W-1:0]  generation_count = '0;
  logic              out_ready = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [SIZE_W-1:0] cfg_data = '0;
  logic              in_ready;
  logic              out_valid;
  logic              cell_out;
  logic [CNT_W-1:0]  live_count;
  logic              cfg_ready;

  // Transactions waiting to be sent, and readouts predicted but not yet seen.
  ca_item_t ca_item_queue[$];
  readout_t readout_queue[$];
  ca_item_t cur_item;

  // Set from the edge a transaction is put on the bus until the edge it is taken.
  bit sending = 1'b0;

  // When set, neither side inserts idle cycles.
  bit steady = 1'b0;

  // Predicted engine state: the whole cell array plus the four registers.
  bit [CELLS-1:0]    board = '0;
  logic [SIZE_W-1:0] rows_reg = ROWS_RESET;
  logic [SIZE_W-1:0] cols_reg = COLS_RESET;
  bit                vote_rule = 1'b0;
  bit                torus = 1'b1;

  // Bookkeeping for the checks and the closing summary.
  int    mismatches = 0;
  int    n_checked = 0;
  int    n_writes = 0;
  int    n_reads = 0;
  int    n_advances = 0;
  int    n_unused = 0;
  int    n_outside = 0;
  int    n_cfg_writes = 0;
  longint gens_requested = 0;

  binary_ca_generation_engine_top dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .row_index        (row_index),
    .col_index        (col_index),
    .cell_in          (cell_in),
    .generation_count (generation_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .cell_out         (cell_out),
    .live_count       (live_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // A size register of zero acts as one; anything above the array saturates.
  function automatic int used_size(input logic [SIZE_W-1:0] raw, input int limit);
    if (raw == '0) return 1;
    if (int'(raw) > limit) return limit;
    return int'(raw);
  endfunction

  // One generation over the used nr by nc corner. Cells outside it are copied
  // through untouched, so they reappear unchanged if the grid grows later.
  function automatic bit [CELLS-1:0] next_generation(input bit [CELLS-1:0] g,
                                                     input int nr, input int nc);
    bit [CELLS-1:0] n;
    int r, c, dr, dc, rr, cc, sum, here;
    n = g;
    for (r = 0; r < nr; r++) begin
      for (c = 0; c < nc; c++) begin
        sum = 0;
        for (dr = -1; dr <= 1; dr++) begin
          for (dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if (dr == 0 && dc == 0) continue;
            // On a tiny torus several neighbor positions can land on the same
            // cell, and each position counts on its own.
            if (torus) begin
              rr = (rr + nr) % nr;
              cc = (cc + nc) % nc;
            end else if (rr < 0 || cc < 0 || rr >= nr || cc >= nc) begin
              continue;
            end
            sum += g[rr * MAX_COLS + cc];
          end
        end
        here = r * MAX_COLS + c;
        if (vote_rule) begin
          n[here] = ANNEAL_VOTE[sum + g[here]];
        end else begin
          n[here] = (sum == BIRTH_SUM) || (sum == SURVIVE_SUM && g[here]);
        end
      end
    end
    return n;
  endfunction

  function automatic logic [CNT_W-1:0] live_cells(input int nr, input int nc);
    int r, c, n;
    n = 0;
    for (r = 0; r < nr; r++) begin
      for (c = 0; c < nc; c++) begin
        n += board[r * MAX_COLS + c];
      end
    end
    if (n > COUNT_CAP) n = COUNT_CAP;
    return CNT_W'(n);
  endfunction

  // Applies one accepted transaction to the predicted grid and returns the
  // readout that the engine owes for it.
  function automatic readout_t apply_ca_item(input ca_item_t it);
    readout_t       res;
    int             nr, nc, idx, gens;
    bit             in_grid, have_older, period2;
    bit [CELLS-1:0] nxt, older;
    nr = used_size(rows_reg, MAX_ROWS);
    nc = used_size(cols_reg, MAX_COLS);
    in_grid = (int'(it.row) < nr) && (int'(it.col) < nc);
    idx = int'(it.row) * MAX_COLS + int'(it.col);
    res.cell_bit = 1'b0;
    case (it.op)
      OP_WRITE: begin
        n_writes++;
        if (in_grid) board[idx] = it.val;
        else n_outside++;
      end
      OP_ADVANCE: begin
        n_advances++;
        gens = int'(it.gens);
        gens_requested += gens;
        have_older = 1'b0;
        older = board;
        // Stopping at a still life or a period-two oscillation gives the same
        // grid as running every generation, and keeps long advances cheap here.
        while (gens > 0) begin
          nxt = next_generation(board, nr, nc);
          gens--;
          if (nxt == board) break;
          period2 = have_older && (nxt == older);
          older = board;
          board = nxt;
          have_older = 1'b1;
          if (period2) begin
            if (gens % 2 == 1) board = older;
            break;
          end
        end
      end
      OP_READ: begin
        n_reads++;
        if (in_grid) res.cell_bit = board[idx];
        else n_outside++;
      end
      default: n_unused++;
    endcase
    res.count = live_cells(nr, nc);
    return res;
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      if (want < 0) begin
        $display("readout %0d arrived with nothing predicted (live_count %0d)",
                 n_checked, got);
      end else begin
        $display("readout %0d: %s expected %0d, got %0d", n_checked, what, want, got);
      end
    end
  endtask

  // Driver: presents queued transactions, holding each one steady until the
  // engine takes it. The prediction is made at the edge of acceptance, so it
  // always follows the order in which the engine saw the transactions.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sending = 1'b0;
        readout_queue.insert(readout_queue.size(), apply_ca_item(cur_item));
      end
      if (!in_valid || in_ready) begin
        if (ca_item_queue.size() != 0 &&
            (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
          cur_item = ca_item_queue.pop_front();
          sending = 1'b1;
          in_valid         <= 1'b1;
          operation        <= cur_item.op;
          row_index        <= cur_item.row;
          col_index        <= cur_item.col;
          cell_in          <= cur_item.val;
          generation_count <= cur_item.gens;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the result channel at random and checks every accepted
  // readout against the oldest prediction, field by field.
  always @(posedge clk) begin
    readout_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_checked++;
        if (readout_queue.size() == 0) begin
          note_mismatch("unexpected", -1, int'(live_count));
        end else begin
          want = readout_queue.pop_front();
          if (cell_out !== want.cell_bit) begin
            note_mismatch("cell_out", int'(want.cell_bit), int'(cell_out));
          end
          if (live_count !== want.count) begin
            note_mismatch("live_count", int'(want.count), int'(live_count));
          end
        end
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  task automatic push_item(input logic [1:0] op, input logic [5:0] row,
                           input logic [5:0] col, input logic val,
                           input logic [GEN_W-1:0] gens);
    ca_item_t it;
    it.op = op;
    it.row = row;
    it.col = col;
    it.val = val;
    it.gens = gens;
    ca_item_queue.insert(ca_item_queue.size(), it);
  endtask

  // Returns once every queued transaction has been taken and every predicted
  // readout has come back, which leaves the engine idle.
  task automatic wait_drained();
    do @(posedge clk);
    while (ca_item_queue.size() != 0 || sending || readout_queue.size() != 0);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [SIZE_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ROWS: rows_reg = data;
      CFG_COLS: cols_reg = data;
      CFG_RULE: vote_rule = data[0];
      CFG_WRAP: torus = data[0];
      default: ;
    endcase
    n_cfg_writes++;
  endtask

  task automatic set_config(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols,
                            input logic [SIZE_W-1:0] rule, input logic [SIZE_W-1:0] wrap);
    wait_drained();
    cfg_write(CFG_ROWS, rows);
    cfg_write(CFG_COLS, cols);
    cfg_write(CFG_RULE, rule);
    cfg_write(CFG_WRAP, wrap);
  endtask

  // Mostly small grids keep the per-cell sweeps short; now and then a size of
  // zero or a size at or past the maximum comes up.
  function automatic logic [SIZE_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 10) return SIZE_W'($urandom_range(127));
    return SIZE_W'($urandom_range(12, 1));
  endfunction

  // A random phase: a fresh configuration, then a mix dominated by cell writes
  // and reads inside the used grid with advances among them, so that patterns
  // build up and evolve. A few accesses land anywhere in the index range, and
  // a few transactions carry the unused operation.
  task automatic random_phase(input int n_items);
    int               nr, nc, i, kind;
    logic [5:0]       row, col;
    logic [GEN_W-1:0] gens;
    set_config(pick_size(), pick_size(), SIZE_W'($urandom_range(127)),
               SIZE_W'($urandom_range(127)));
    nr = used_size(rows_reg, MAX_ROWS);
    nc = used_size(cols_reg, MAX_COLS);
    for (i = 0; i < n_items; i++) begin
      kind = $urandom_range(99);
      row = 6'($urandom_range(nr - 1));
      col = 6'($urandom_range(nc - 1));
      if ($urandom_range(9) == 0) begin
        row = 6'($urandom_range(63));
        col = 6'($urandom_range(63));
      end
      if (kind < 45) begin
        push_item(OP_WRITE, row, col, 1'($urandom_range(1)), GEN_W'($urandom));
      end else if (kind < 65) begin
        // On large grids an advance asks for at most one generation, since each one sweeps every used cell.
        gens = (nr * nc > 256) ? GEN_W'($urandom_range(1)) : GEN_W'($urandom_range(15));
        push_item(OP_ADVANCE, row, col, 1'($urandom_range(1)), gens);
      end else if (kind < 95) begin
        push_item(OP_READ, row, col, 1'($urandom_range(1)), GEN_W'($urandom));
      end else begin
        push_item(OP_UNUSED, 6'($urandom), 6'($urandom), 1'($urandom_range(1)),
                  GEN_W'($urandom));
      end
    end
  endtask

  initial begin
    int p;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration, a full 64 by 64 torus under Life. A cell is read
    // from the cleared grid, then the four corners are set: across the wrap
    // they form one still block, so a single generation must keep all four.
    push_item(OP_READ, 6'd0, 6'd0, 1'b0, '0);
    push_item(OP_WRITE, 6'd63, 6'd63, 1'b1, '0);
    push_item(OP_WRITE, 6'd0, 6'd0, 1'b1, '0);
    push_item(OP_WRITE, 6'd0, 6'd63, 1'b1, '0);
    push_item(OP_WRITE, 6'd63, 6'd0, 1'b1, '0);
    push_item(OP_ADVANCE, 6'd0, 6'd0, 1'b0, GEN_W'(1));
    push_item(OP_READ, 6'd63, 6'd63, 1'b0, '0);

    // A 5 by 5 grid with dead edges. A blinker flips once, then runs three
    // more generations so the period-two shortcut has to land on the odd
    // phase. Accesses past the used grid, the unused operation with every
    // field at its top value, and an advance by zero generations come between.
    set_config(SIZE_W'(5), SIZE_W'(5), SIZE_W'(0), SIZE_W'(0));
    push_item(OP_WRITE, 6'd2, 6'd1, 1'b1, '0);
    push_item(OP_WRITE, 6'd2, 6'd2, 1'b1, '0);
    push_item(OP_WRITE, 6'd2, 6'd3, 1'b1, '0);
    push_item(OP_ADVANCE, 6'd0, 6'd0, 1'b0, GEN_W'(1));
    push_item(OP_READ, 6'd1, 6'd2, 1'b0, '0);
    push_item(OP_WRITE, 6'd7, 6'd7, 1'b1, '0);
    push_item(OP_READ, 6'd40, 6'd3, 1'b0, '0);
    push_item(OP_UNUSED, 6'd63, 6'd63, 1'b1, '1);
    push_item(OP_ADVANCE, 6'd2, 6'd2, 1'b1, '0);
    push_item(OP_ADVANCE, 6'd0, 6'd0, 1'b0, GEN_W'(3));

    // Both size registers at zero give a single wrapped cell under the anneal
    // vote: all eight neighbor positions are the cell itself. The longest
    // possible advance runs here, where one generation is cheapest.
    set_config(SIZE_W'(0), SIZE_W'(0), SIZE_W'(1), SIZE_W'(1));
    push_item(OP_WRITE, 6'd0, 6'd0, 1'b1, '0);
    push_item(OP_ADVANCE, 6'd0, 6'd0, 1'b0, '1);
    push_item(OP_READ, 6'd0, 6'd0, 1'b0, '0);

    // Rows past the maximum saturate to 64, on a torus only two columns wide.
    set_config('1, SIZE_W'(2), SIZE_W'(0), SIZE_W'(1));
    push_item(OP_WRITE, 6'd5, 6'd0, 1'b1, '0);
    push_item(OP_WRITE, 6'd5, 6'd1, 1'b1, '0);
    push_item(OP_WRITE, 6'd6, 6'd0, 1'b1, '0);
    push_item(OP_ADVANCE, 6'd0, 6'd0, 1'b0, GEN_W'(4));

    // Columns past the maximum, two rows, dead edges: the far corner written
    // at the start comes back into view.
    set_config(SIZE_W'(2), '1, SIZE_W'(1), SIZE_W'(0));
    push_item(OP_READ, 6'd0, 6'd63, 1'b0, '0);
    push_item(OP_ADVANCE, 6'd0, 6'd0, 1'b0, GEN_W'(2));

    // Random phases. Each one starts only after the engine has drained, so the
    // sender pauses with nothing outstanding before every reconfiguration.
    // One phase runs with no idle cycles on either side.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      random_phase(PHASE_ITEMS);
      wait_drained();
      steady = (p + 1 == STEADY_PHASE);
    end
    steady = 1'b0;

    // Leave room for any stray result to show up after the last expected one.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d writes, %0d reads, %0d advances (%0d generations asked), %0d unused ops.",
             n_writes, n_reads, n_advances, gens_requested, n_unused);
    $display("Checked %0d readouts over %0d register writes; %0d accesses fell off the grid.",
             n_checked, n_cfg_writes, n_outside);
    if (mismatches == 0 && readout_queue.size() == 0) begin
      $display("binary_ca_generation_engine_top: match");
    end else begin
      $display("binary_ca_generation_engine_top: mismatch");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run, including the single-cell
  // advance through every generation that a 16-bit count allows.
  initial begin
    #96000000;
    $display("binary_ca_generation_engine_top: mismatch");
    $finish;
  end

endmodule
